@@ rtl/tqsa_pkg.sv @@
// Shared types and constants for the twin queue block.
package tqsa_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_A = 2'd0,
    ACT_INS_B = 2'd1,
    ACT_REM_A = 2'd2,
    ACT_REM_B = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the accepted transaction
    logic exec;    // update pointers and access storage
    logic ld_out;  // load the result register
  } ctrl_cmd_t;

endpackage

@@ rtl/tqsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tqsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/tqsa_ctrl.sv @@
// Controller: sequences accept, execute and result hand-off for each transaction.
module tqsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output tqsa_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  // Result register can take a new word if empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.exec   = (state_r == S_EXEC);
    cmd.ld_out = (state_r == S_FIN) && out_free;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/tqsa_dp.sv @@
// Datapath: queue pointers, storage access and result register.
module tqsa_dp #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tqsa_pkg::ctrl_cmd_t                  cmd,
  input  logic [tqsa_pkg::ACTION_W-1:0]        in_action,
  input  logic signed [tqsa_pkg::VALUE_W-1:0]  in_value,
  output logic signed [tqsa_pkg::VALUE_W-1:0]  out_read_value,
  output logic [tqsa_pkg::STATUS_W-1:0]        out_status
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (DATA_WIDTH > tqsa_pkg::VALUE_W) ? DATA_WIDTH
                                                                  : tqsa_pkg::VALUE_W;
  localparam logic [PW-1:0] P_ONE   = PW'(1);
  localparam logic [PW-1:0] P_DEPTH = PW'(DEPTH);

  // A pointers are held plus one, so zero means empty; B pointers at DEPTH mean empty
  logic [PW-1:0]          a_front_r, a_front_nxt;
  logic [PW-1:0]          a_rear_r,  a_rear_nxt;
  logic [PW-1:0]          b_front_r, b_front_nxt;
  logic [PW-1:0]          b_rear_r,  b_rear_nxt;
  tqsa_pkg::action_t      action_r;
  logic [DATA_WIDTH-1:0]  value_r;
  tqsa_pkg::status_t      status_r, status_nxt;
  logic                   rd_sel_r, rd_sel_nxt;
  logic [tqsa_pkg::VALUE_W-1:0] read_value_r;
  logic [tqsa_pkg::STATUS_W-1:0] out_status_r;

  logic                   full;
  logic                   ram_we;
  logic                   ram_re;
  logic [PW-1:0]          waddr_p;
  logic [PW-1:0]          raddr_p;
  logic [DATA_WIDTH-1:0]  ram_rdata;
  logic [XW-1:0]          in_ext;
  logic [XW-1:0]          rd_ext;

  assign in_ext = XW'($unsigned(in_value));
  assign rd_ext = XW'(ram_rdata);
  assign full   = (a_rear_r == b_rear_r);

  always_comb begin
    a_front_nxt = a_front_r;
    a_rear_nxt  = a_rear_r;
    b_front_nxt = b_front_r;
    b_rear_nxt  = b_rear_r;
    status_nxt  = tqsa_pkg::ST_DONE;
    rd_sel_nxt  = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    waddr_p     = a_rear_r;
    raddr_p     = a_front_r - P_ONE;
    unique case (action_r)
      tqsa_pkg::ACT_INS_A: begin
        if (full) begin
          status_nxt = tqsa_pkg::ST_OVERFLOW;
        end else begin
          ram_we     = cmd.exec;
          waddr_p    = a_rear_r;
          a_rear_nxt = a_rear_r + P_ONE;
          if (a_front_r == '0) begin
            a_front_nxt = P_ONE;
          end
        end
      end
      tqsa_pkg::ACT_INS_B: begin
        if (full) begin
          status_nxt = tqsa_pkg::ST_OVERFLOW;
        end else begin
          ram_we     = cmd.exec;
          waddr_p    = b_rear_r - P_ONE;
          b_rear_nxt = b_rear_r - P_ONE;
          if (b_front_r == P_DEPTH) begin
            b_front_nxt = P_DEPTH - P_ONE;
          end
        end
      end
      tqsa_pkg::ACT_REM_A: begin
        if (a_front_r == '0) begin
          status_nxt = tqsa_pkg::ST_UNDERFLOW;
        end else begin
          ram_re     = cmd.exec;
          rd_sel_nxt = 1'b1;
          raddr_p    = a_front_r - P_ONE;
          // Drained: return both pointers to the empty mark
          if (a_front_r == a_rear_r) begin
            a_front_nxt = '0;
            a_rear_nxt  = '0;
          end else begin
            a_front_nxt = a_front_r + P_ONE;
          end
        end
      end
      tqsa_pkg::ACT_REM_B: begin
        if (b_front_r == P_DEPTH) begin
          status_nxt = tqsa_pkg::ST_UNDERFLOW;
        end else begin
          ram_re     = cmd.exec;
          rd_sel_nxt = 1'b1;
          raddr_p    = b_front_r;
          if (b_front_r == b_rear_r) begin
            b_front_nxt = P_DEPTH;
            b_rear_nxt  = P_DEPTH;
          end else begin
            b_front_nxt = b_front_r - P_ONE;
          end
        end
      end
      default: begin
        status_nxt = tqsa_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_front_r <= '0;
      a_rear_r  <= '0;
      b_front_r <= P_DEPTH;
      b_rear_r  <= P_DEPTH;
    end else if (cmd.exec) begin
      a_front_r <= a_front_nxt;
      a_rear_r  <= a_rear_nxt;
      b_front_r <= b_front_nxt;
      b_rear_r  <= b_rear_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= tqsa_pkg::action_t'(in_action);
      value_r  <= in_ext[DATA_WIDTH-1:0];
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      rd_sel_r <= rd_sel_nxt;
    end
    if (cmd.ld_out) begin
      read_value_r <= rd_sel_r ? rd_ext[tqsa_pkg::VALUE_W-1:0] : '0;
      out_status_r <= status_r;
    end
  end

  tqsa_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_p[AW-1:0]),
    .wdata (value_r),
    .re    (ram_re),
    .raddr (raddr_p[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign out_read_value = $signed(read_value_r);
  assign out_status     = out_status_r;

endmodule

@@ rtl/twin_queue_shared_array.sv @@
// Top level: two FIFO queues sharing one storage array.
//
// Input channel: in_valid/in_stall carry one action (in_action) and a data
// word (in_value). Actions: insert into A, insert into B, remove from A,
// remove from B. Queue A fills from the bottom of the array, queue B from
// the top; an insert is refused with overflow when the two rears meet, a
// remove from an empty queue reports underflow.
// Result channel: out_valid/out_stall carry exactly one result per input
// transaction: out_read_value (removed word, zero otherwise) and out_status.
// After the input is accepted, the result comes from a pointer update with
// storage access, then a result register load.
// The controller works on one transaction at a time and takes no new input
// until the last one has left the finish step; the registered storage read
// sets the execute/finish split. A new input is taken while a finished result
// still waits in the output register.
// When the receiver stalls, the result holds and the next transaction
// waits in the finish step until the output register is free.
// Reset (rst_n low, synchronous): both queues empty, no result pending.
// Storage contents are not cleared and are never read before written.
module twin_queue_shared_array #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tqsa_pkg::ACTION_W-1:0]       in_action,
  input  logic signed [tqsa_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tqsa_pkg::VALUE_W-1:0] out_read_value,
  output logic [tqsa_pkg::STATUS_W-1:0]       out_status
);

  tqsa_pkg::ctrl_cmd_t cmd;

  tqsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tqsa_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_action      (in_action),
    .in_value       (in_value),
    .out_read_value (out_read_value),
    .out_status     (out_status)
  );

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the twin queue block: queued driver, checking monitor.
module testbench;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned RANDOM_ITEMS  = 850;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned VALUE_W       = tqsa_pkg::VALUE_W;
  localparam int unsigned ACTION_W      = tqsa_pkg::ACTION_W;
  localparam int unsigned STATUS_W      = tqsa_pkg::STATUS_W;

  typedef struct {
    tqsa_pkg::action_t          action;
    logic signed [VALUE_W-1:0]  value;
  } request_t;

  typedef struct {
    logic signed [VALUE_W-1:0]  read_value;
    tqsa_pkg::status_t          status;
  } outcome_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [ACTION_W-1:0]         in_action = '0;
  logic signed [VALUE_W-1:0]   in_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [VALUE_W-1:0]   out_read_value;
  logic [STATUS_W-1:0]         out_status;

  // Predictor state: A holds a_head..a_tail, B holds b_tail..b_head
  logic [VALUE_W-1:0]          cells [DEPTH];
  int                          a_head = -1;
  int                          a_tail = -1;
  int                          b_head = DEPTH;
  int                          b_tail = DEPTH;

  request_t                    pending_requests [$];
  outcome_t                    outcomes_due [$];
  int unsigned                 total_requests = 0;
  int unsigned                 accepted_count = 0;
  int unsigned                 mismatch_count = 0;
  int unsigned                 cycle_count = 0;

  twin_queue_shared_array #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(VALUE_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_read_value(out_read_value),
    .out_status(out_status)
  );

  always #2 clk = ~clk;

  // Work out the outcome of one action and advance the queue pointers
  function automatic outcome_t apply_action(tqsa_pkg::action_t act,
                                            logic signed [VALUE_W-1:0] word);
    outcome_t res;
    logic     full;
    res.read_value = '0;
    res.status = tqsa_pkg::ST_DONE;
    full = (a_tail == b_tail - 1);
    case (act)
      tqsa_pkg::ACT_INS_A: begin
        if (full) begin
          res.status = tqsa_pkg::ST_OVERFLOW;
        end else begin
          if (a_head == -1) begin
            a_head = 0;
            a_tail = 0;
          end else begin
            a_tail++;
          end
          cells[a_tail] = word;
        end
      end
      tqsa_pkg::ACT_INS_B: begin
        if (full) begin
          res.status = tqsa_pkg::ST_OVERFLOW;
        end else begin
          if (b_head == DEPTH) begin
            b_head = DEPTH - 1;
            b_tail = DEPTH - 1;
          end else begin
            b_tail--;
          end
          cells[b_tail] = word;
        end
      end
      tqsa_pkg::ACT_REM_A: begin
        if (a_head == -1) begin
          res.status = tqsa_pkg::ST_UNDERFLOW;
        end else begin
          res.read_value = cells[a_head];
          a_head++;
          // drained: return to the bottom end
          if (a_head > a_tail) begin
            a_head = -1;
            a_tail = -1;
          end
        end
      end
      default: begin
        if (b_head == DEPTH) begin
          res.status = tqsa_pkg::ST_UNDERFLOW;
        end else begin
          res.read_value = cells[b_head];
          b_head--;
          if (b_head < b_tail) begin
            b_head = DEPTH;
            b_tail = DEPTH;
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic int unsigned traffic_phase();
    if (total_requests == 0) return 0;
    return (accepted_count * 4) / total_requests;
  endfunction

  function automatic logic sender_pauses();
    case (traffic_phase())
      1: return $urandom_range(0, 99) < 81;
      3: return $urandom_range(0, 99) < 20;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls();
    case (traffic_phase())
      2: return $urandom_range(0, 99) < 81;
      3: return $urandom_range(0, 99) < 20;
      default: return 1'b0;
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", what);
  endtask

  task automatic queue_request(tqsa_pkg::action_t act, logic signed [VALUE_W-1:0] word);
    request_t req;
    req.action = act;
    req.value = word;
    pending_requests.push_back(req);
  endtask

  // Driver: hold a stalled transaction, otherwise present the next one or idle
  always @(posedge clk) begin
    request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        outcomes_due.push_back(apply_action(tqsa_pkg::action_t'(in_action), in_value));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && !sender_pauses()) begin
          req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_action <= req.action;
          in_value <= req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest outcome due
  always @(posedge clk) begin
    outcome_t due;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcomes_due.size() == 0) begin
          flag_mismatch($sformatf("result with nothing due: read_value %0d status %0d",
                                  out_read_value, out_status));
        end else begin
          due = outcomes_due.pop_front();
          if (out_read_value !== due.read_value)
            flag_mismatch($sformatf("read_value expected %0d got %0d",
                                    due.read_value, out_read_value));
          if (out_status !== due.status)
            flag_mismatch($sformatf("status expected %0d got %0d", due.status, out_status));
        end
      end
      out_stall <= receiver_stalls();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int unsigned made;
    int unsigned mood;
    int unsigned burst;
    int unsigned roll;
    logic        on_b;
    logic        adds;
    logic signed [VALUE_W-1:0] word;

    // empty removals, extremes, drain of both queues
    queue_request(tqsa_pkg::ACT_REM_A, 32'sd0);
    queue_request(tqsa_pkg::ACT_REM_B, 32'sd0);
    queue_request(tqsa_pkg::ACT_INS_A, 32'h7fff_ffff);
    queue_request(tqsa_pkg::ACT_INS_B, 32'h8000_0000);
    queue_request(tqsa_pkg::ACT_REM_A, 32'hffff_ffff);
    queue_request(tqsa_pkg::ACT_REM_B, 32'h0000_0000);
    // fill the whole array, then hit overflow from both sides
    queue_request(tqsa_pkg::ACT_INS_A, 32'h0000_0000);
    queue_request(tqsa_pkg::ACT_INS_A, 32'hffff_ffff);
    queue_request(tqsa_pkg::ACT_INS_A, 32'h5555_5555);
    queue_request(tqsa_pkg::ACT_INS_A, 32'haaaa_aaaa);
    for (int k = 0; k < 5; k++) queue_request(tqsa_pkg::ACT_INS_A, $urandom);
    for (int k = 0; k < 7; k++) queue_request(tqsa_pkg::ACT_INS_B, $urandom);
    queue_request(tqsa_pkg::ACT_INS_B, 32'h1234_5678);
    queue_request(tqsa_pkg::ACT_INS_A, 32'h1234_5678);
    // freed space at the front of A stays unusable while A holds data
    queue_request(tqsa_pkg::ACT_REM_A, 32'sd0);
    queue_request(tqsa_pkg::ACT_INS_A, 32'h0bad_cafe);
    queue_request(tqsa_pkg::ACT_REM_B, 32'sd0);

    // bursts biased toward filling or draining, balanced bursts, or bursts on one queue only
    made = 0;
    while (made < RANDOM_ITEMS) begin
      mood = $urandom_range(0, 3);
      burst = $urandom_range(8, 40);
      on_b = $urandom_range(0, 1);
      for (int k = 0; k < burst && made < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        case (mood)
          0: adds = roll < 85;
          1: adds = roll < 15;
          default: adds = roll < 50;
        endcase
        if (mood != 3) on_b = $urandom_range(0, 1);
        case ($urandom_range(0, 9))
          0: word = 32'h7fff_ffff;
          1: word = 32'h8000_0000;
          default: word = $urandom;
        endcase
        if (adds) queue_request(on_b ? tqsa_pkg::ACT_INS_B : tqsa_pkg::ACT_INS_A, word);
        else queue_request(on_b ? tqsa_pkg::ACT_REM_B : tqsa_pkg::ACT_REM_A, word);
        made++;
      end
    end
    total_requests = pending_requests.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid || outcomes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
